// ===== design/pvs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and rounding helpers for the Phong vertex shader.
// No dependencies; imported by pvs_norm, phong_vertex_shader_unit and tb_top.
package pvs_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // normalizer input component and magnitude widths
  localparam int unsigned VEC_W      = 34;
  localparam int unsigned MAG_W      = VEC_W - 1;
  localparam int unsigned SCL_W      = 30;
  localparam int unsigned SQ_STAGES  = 32;
  localparam int unsigned NORM_BASE_LAT = 6 + SQ_STAGES;
  localparam int unsigned POW_STAGES = 127;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned SHIN_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_POS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPECULAR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHININESS  = 3'd7;

  localparam logic [47:0] RST_LIGHT_POS = 48'hFE48_0960_F8F8;
  localparam logic [47:0] RST_VIEW_POS  = 48'h00F0_00F0_0000;
  localparam logic [47:0] RST_LIGHT_COL = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] RST_AMBIENT   = 48'h8000_199A_0000;
  localparam logic [47:0] RST_DIFFUSE   = 48'hCCCC_3333_0000;
  localparam logic [47:0] RST_SPECULAR  = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] RST_COEFF     = 64'h2000_4000_2666_0CCD;
  localparam logic [SHIN_W-1:0] RST_SHININESS = 7'd5;

  typedef logic signed [VEC_W-1:0] comp_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  // signed shift right, rounding half away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x,
                                                input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] x,
                                                    input int unsigned f);
    logic signed [63:0] one;
    one = 64'sd1 <<< f;
    if (x > one) return one;
    if (x < -one) return -one;
    return x;
  endfunction

endpackage

// ===== design/pvs_norm.sv =====
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: range scaling, sum of squares, square root, division.
// Depends on pvs_pkg.
module pvs_norm #(
  parameter int unsigned FRAC_BITS = pvs_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pvs_pkg::pipe_ctl_t         ctl_i,
  input  pvs_pkg::comp_t             vec_i [3],
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output logic [SIDE_W-1:0]          side_o
);
  import pvs_pkg::*;

  localparam int unsigned QW         = FRAC_BITS + 1;
  localparam int unsigned DIV_STAGES = FRAC_BITS + 1;
  localparam int unsigned POS_W      = $clog2(MAG_W);
  localparam int unsigned SCL_TOP    = SCL_W - 1;

  typedef struct packed {
    logic [2:0][SCL_W-1:0] m;
    logic [2:0]            s;
    logic                  z;
    logic [SIDE_W-1:0]     side;
  } carry_t;

  // stage 1: magnitudes
  logic [MAG_W-1:0]  m1_q [3];
  logic [2:0]        s1_q;
  logic [SIDE_W-1:0] side1_q;
  logic              v1_q;

  // stage 2: scale amounts
  logic [MAG_W-1:0]  m2_q [3];
  logic [2:0]        s2_q;
  logic [SIDE_W-1:0] side2_q;
  logic              z2_q;
  logic [POS_W-1:0]  lsh2_q, rsh2_q;
  logic              v2_q;

  logic [MAG_W-1:0]  mx;
  logic [POS_W-1:0]  pos;

  // stage 3 and 4: scaled components, squares
  carry_t            c3_q, c3_d, c4_q;
  logic [63:0]       wide [3];
  logic [2*SCL_W-1:0] sq4_q [3];
  logic              v3_q, v4_q;

  // square root iterations
  logic [63:0]       rx_q [SQ_STAGES+1];
  logic [63:0]       rr_q [SQ_STAGES+1];
  carry_t            rc_q [SQ_STAGES+1];
  logic [SQ_STAGES:0] rv_q;
  logic [63:0]       rx_d [SQ_STAGES];
  logic [63:0]       rr_d [SQ_STAGES];

  // division iterations
  logic [63:0]       dr_q [DIV_STAGES+1][3];
  logic [QW-1:0]     dq_q [DIV_STAGES+1][3];
  logic [31:0]       dl_q [DIV_STAGES+1];
  carry_t            dc_q [DIV_STAGES+1];
  logic [DIV_STAGES:0] dv_q;
  logic [63:0]       dr_d [DIV_STAGES][3];
  logic [QW-1:0]     dq_d [DIV_STAGES][3];

  always_comb begin
    mx = m1_q[0];
    if (m1_q[1] > mx) mx = m1_q[1];
    if (m1_q[2] > mx) mx = m1_q[2];
    pos = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx[b]) pos = POS_W'(b);
    end
  end

  always_comb begin
    c3_d.s    = s2_q;
    c3_d.z    = z2_q;
    c3_d.side = side2_q;
    for (int i = 0; i < 3; i++) begin
      wide[i]   = (64'(m2_q[i]) << lsh2_q) >> rsh2_q;
      c3_d.m[i] = wide[i][SCL_W-1:0];
    end
  end

  always_comb begin
    logic [63:0] bitv;
    logic [63:0] t;
    for (int k = 0; k < SQ_STAGES; k++) begin
      bitv = 64'd1 << (62 - 2 * k);
      t    = rr_q[k] + bitv;
      if (rx_q[k] >= t) begin
        rx_d[k] = rx_q[k] - t;
        rr_d[k] = (rr_q[k] >> 1) + bitv;
      end else begin
        rx_d[k] = rx_q[k];
        rr_d[k] = rr_q[k] >> 1;
      end
    end
  end

  always_comb begin
    logic [63:0] dvs;
    for (int j = 0; j < DIV_STAGES; j++) begin
      dvs = 64'(dl_q[j]) << (FRAC_BITS - j);
      for (int i = 0; i < 3; i++) begin
        dq_d[j][i] = dq_q[j][i];
        if (dr_q[j][i] >= dvs) begin
          dr_d[j][i] = dr_q[j][i] - dvs;
          dq_d[j][i][FRAC_BITS - j] = 1'b1;
        end else begin
          dr_d[j][i] = dr_q[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      rv_q <= '0;
      dv_q <= '0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      rv_q <= {rv_q[SQ_STAGES-1:0], v4_q};
      dv_q <= {dv_q[DIV_STAGES-1:0], rv_q[SQ_STAGES]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        m1_q[i] <= vec_i[i][VEC_W-1] ? MAG_W'(-vec_i[i]) : MAG_W'(vec_i[i]);
        s1_q[i] <= vec_i[i][VEC_W-1];
        m2_q[i] <= m1_q[i];
        sq4_q[i] <= (2*SCL_W)'(c3_q.m[i]) * (2*SCL_W)'(c3_q.m[i]);
      end
      side1_q <= side_i;
      s2_q    <= s1_q;
      side2_q <= side1_q;
      z2_q    <= (mx == '0);
      lsh2_q  <= (pos < POS_W'(SCL_TOP)) ? POS_W'(SCL_TOP) - pos : '0;
      rsh2_q  <= (pos > POS_W'(SCL_TOP)) ? pos - POS_W'(SCL_TOP) : '0;
      c3_q    <= c3_d;
      c4_q    <= c3_q;
      rx_q[0] <= 64'(sq4_q[0]) + 64'(sq4_q[1]) + 64'(sq4_q[2]);
      rr_q[0] <= '0;
      rc_q[0] <= c4_q;
      for (int k = 0; k < SQ_STAGES; k++) begin
        rx_q[k+1] <= rx_d[k];
        rr_q[k+1] <= rr_d[k];
        rc_q[k+1] <= rc_q[k];
      end
      dl_q[0] <= rr_q[SQ_STAGES][31:0];
      dc_q[0] <= rc_q[SQ_STAGES];
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= (64'(rc_q[SQ_STAGES].m[i]) << FRAC_BITS) + (rr_q[SQ_STAGES] >> 1);
        dq_q[0][i] <= '0;
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
        dl_q[j+1] <= dl_q[j];
        dc_q[j+1] <= dc_q[j];
        for (int i = 0; i < 3; i++) begin
          dr_q[j+1][i] <= dr_d[j][i];
          dq_q[j+1][i] <= dq_d[j][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dc_q[DIV_STAGES].z) begin
        unit_o[i] = '0;
      end else if (dc_q[DIV_STAGES].s[i]) begin
        unit_o[i] = -$signed({1'b0, dq_q[DIV_STAGES][i]});
      end else begin
        unit_o[i] = $signed({1'b0, dq_q[DIV_STAGES][i]});
      end
    end
  end

  assign valid_o = dv_q[DIV_STAGES];
  assign side_o  = dc_q[DIV_STAGES].side;

endmodule

// ===== design/phong_vertex_shader_unit.sv =====
`timescale 1ns / 1ps
// Per-vertex Phong lighting pipeline: top level with configuration registers.
// Depends on pvs_pkg and pvs_norm.
//
// Usage:
//   s_axis carries one vertex per transfer: point and normal in tdata, vertex
//   slot in tuser. m_axis returns one 8-bit red, green, blue result per vertex
//   in the same order, with the slot copied to tuser.
//   The cfg channel writes one register per transfer (index, 64-bit data); it
//   is always ready. Write it only while no vertex is in flight.
// Datapath: two normalizers in series (square root and divider iterations) and the
//   127-stage specular power chain lie between input transfer and output valid.
// Throughput: one vertex per cycle while the output is not stalled.
// Reset: all valid bits clear, registers take their default light setup.
// Stall: while m_axis_tvalid is high and m_axis_tready low the whole pipeline
//   holds and s_axis_tready is low; nothing is dropped or repeated.
module phong_vertex_shader_unit #(
  parameter int unsigned COORD_BITS = pvs_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pvs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z (lowest first)
  input  logic [((3*COORD_BITS+96+7)/8)*8-1:0] s_axis_tdata,
  // vertex_slot
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red, green, blue (lowest first)
  output logic [23:0]                       m_axis_tdata,
  // slot_tag
  output logic [1:0]                        m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pvs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pvs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pvs_pkg::*;

  localparam int unsigned UW     = FRAC_BITS + 2;
  localparam int unsigned RW     = FRAC_BITS + 3;
  localparam int unsigned PW     = 2 * UW;
  localparam int unsigned SIDE_R = 4 * UW + 2;
  localparam int unsigned T_W    = 33 + UW;
  localparam int unsigned IN_W   = 35;
  localparam int unsigned X_W    = 36;
  localparam int unsigned LIT_W  = 39;
  localparam int unsigned AMB_W  = 33;
  localparam logic signed [UW-1:0] UNIT_ONE = UW'(1) << FRAC_BITS;

  // configuration
  logic [47:0]       lpos_q, vpos_q, lcol_q, amb_col_q, dif_q, spec_q;
  logic [63:0]       coef_q;
  logic [SHIN_W-1:0] shin_q;

  logic en;

  // input stage
  logic                          iv_q;
  logic signed [COORD_BITS-1:0]  ip_q [3];
  logic signed [31:0]            in_q [3];
  logic [1:0]                    islot_q;

  comp_t lvec [3], nvec [3], vvec [3], rvec [3];
  pipe_ctl_t ctl_a, ctl_r;

  logic                 l_valid, n_valid, v_valid, r_valid;
  logic signed [UW-1:0] lu [3], nu [3], vu [3], ru [3];
  logic [1:0]           l_side;
  logic [SIDE_R-1:0]    r_side_in, r_side;

  // lighting stages
  logic                 d1_v_q, d2_v_q, d3_v_q, d4_v_q;
  logic signed [PW-1:0] nl_q [3];
  logic signed [UW-1:0] d1_n_q [3], d1_l_q [3], d1_v3_q [3];
  logic signed [UW-1:0] d2_n_q [3], d2_l_q [3], d2_v3_q [3];
  logic signed [UW-1:0] d3_l_q [3], d3_v3_q [3];
  logic signed [UW-1:0] d4_v3_q [3];
  logic [1:0]           d1_s_q, d2_s_q, d3_s_q, d4_s_q;
  logic signed [UW-1:0] d2_ndl_q, d3_ndl_q, d4_ndl_q;
  logic signed [PW-1:0] np_q [3];
  logic signed [RW-1:0] rr_q [3];
  logic signed [63:0]   nl_sum;

  // reflection stages
  logic                 e1_v_q;
  logic signed [PW-1:0] rv_q [3];
  logic signed [UW-1:0] e1_ndl_q;
  logic [1:0]           e1_s_q;
  logic signed [UW-1:0] rs_v [3];
  logic signed [63:0]   rv_sum;

  // specular power chain
  logic signed [UW-1:0] pw_q [POW_STAGES+1];
  logic signed [UW-1:0] pr_q [POW_STAGES+1];
  logic signed [UW-1:0] pn_q [POW_STAGES+1];
  logic [1:0]           ps_q [POW_STAGES+1];
  logic [POW_STAGES:0]  pv_q;
  logic signed [UW-1:0] pw_d [POW_STAGES];

  // colour stages
  logic [31:0]             ad_q [3], kdd_q [3], kss_q [3];
  logic [AMB_W-1:0]        amb_q [3];
  logic signed [T_W-1:0]   t1_q [3], t2_q [3];
  logic signed [IN_W-1:0]  inner_q [3];
  logic signed [X_W-1:0]   x_q [3];
  logic signed [LIT_W-1:0] lit_q [3];
  logic [1:0]              c1_s_q, c2_s_q, c3_s_q, c4_s_q;
  logic                    c1_v_q, c2_v_q, c3_v_q, c4_v_q;
  logic [7:0]              chan [3];

  logic        m_valid_q;
  logic [23:0] m_data_q;
  logic [1:0]  m_user_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpos_q    <= RST_LIGHT_POS;
      vpos_q    <= RST_VIEW_POS;
      lcol_q    <= RST_LIGHT_COL;
      amb_col_q <= RST_AMBIENT;
      dif_q     <= RST_DIFFUSE;
      spec_q    <= RST_SPECULAR;
      coef_q    <= RST_COEFF;
      shin_q    <= RST_SHININESS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LIGHT_POS: lpos_q    <= cfg_data_i[47:0];
        REG_VIEW_POS:  vpos_q    <= cfg_data_i[47:0];
        REG_LIGHT_COL: lcol_q    <= cfg_data_i[47:0];
        REG_AMBIENT:   amb_col_q <= cfg_data_i[47:0];
        REG_DIFFUSE:   dif_q     <= cfg_data_i[47:0];
        REG_SPECULAR:  spec_q    <= cfg_data_i[47:0];
        REG_COEFF:     coef_q    <= cfg_data_i;
        REG_SHININESS: shin_q    <= cfg_data_i[SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration-only products, settled long before any vertex reaches them
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ad_q[i]  <= 32'(dif_q[16*i +: 16]) * 32'(amb_col_q[16*i +: 16]);
      kdd_q[i] <= 32'(coef_q[31:16]) * 32'(dif_q[16*i +: 16]);
      kss_q[i] <= 32'(coef_q[47:32]) * 32'(spec_q[16*i +: 16]);
      amb_q[i] <= AMB_W'(rnd_sh(64'(ad_q[i]), 16)) * AMB_W'(coef_q[15:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvec[i] = VEC_W'(ip_q[i]) - VEC_W'($signed(lpos_q[16*i +: 16]));
      vvec[i] = VEC_W'(ip_q[i]) - VEC_W'($signed(vpos_q[16*i +: 16]));
      nvec[i] = VEC_W'(in_q[i]);
      rvec[i] = VEC_W'(rr_q[i]);
    end
    ctl_a = '{en: en, valid: iv_q};
    ctl_r = '{en: en, valid: d4_v_q};
    r_side_in = {d4_ndl_q, d4_s_q, d4_v3_q[2], d4_v3_q[1], d4_v3_q[0]};
  end

  pvs_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_norm_l (
    .clk_i, .rst_ni, .ctl_i(ctl_a), .vec_i(lvec), .side_i(islot_q),
    .valid_o(l_valid), .unit_o(lu), .side_o(l_side)
  );

  pvs_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_norm_n (
    .clk_i, .rst_ni, .ctl_i(ctl_a), .vec_i(nvec), .side_i(islot_q),
    .valid_o(n_valid), .unit_o(nu), .side_o()
  );

  pvs_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_norm_v (
    .clk_i, .rst_ni, .ctl_i(ctl_a), .vec_i(vvec), .side_i(islot_q),
    .valid_o(v_valid), .unit_o(vu), .side_o()
  );

  pvs_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_R)) u_norm_r (
    .clk_i, .rst_ni, .ctl_i(ctl_r), .vec_i(rvec), .side_i(r_side_in),
    .valid_o(r_valid), .unit_o(ru), .side_o(r_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) rs_v[i] = $signed(r_side[UW*i +: UW]);
    nl_sum = 64'(nl_q[0]) + 64'(nl_q[1]) + 64'(nl_q[2]);
    rv_sum = 64'(rv_q[0]) + 64'(rv_q[1]) + 64'(rv_q[2]);
    for (int k = 0; k < POW_STAGES; k++) begin
      if (7'(k) < shin_q) begin
        pw_d[k] = UW'(clamp_unit(rnd_sh(64'(pw_q[k]) * 64'(pr_q[k]), FRAC_BITS), FRAC_BITS));
      end else begin
        pw_d[k] = pw_q[k];
      end
    end
  end

  always_comb begin
    logic signed [63:0] c;
    logic [63:0] sc;
    for (int i = 0; i < 3; i++) begin
      c = $signed(64'(amb_q[i])) + 64'(lit_q[i]);
      if (c < 0) c = '0;
      if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
      sc = ((64'(c) << 8) - 64'(c) + (64'd1 << 29)) >> 30;
      chan[i] = sc[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q      <= 1'b0;
      d1_v_q    <= 1'b0;
      d2_v_q    <= 1'b0;
      d3_v_q    <= 1'b0;
      d4_v_q    <= 1'b0;
      e1_v_q    <= 1'b0;
      pv_q      <= '0;
      c1_v_q    <= 1'b0;
      c2_v_q    <= 1'b0;
      c3_v_q    <= 1'b0;
      c4_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      iv_q      <= s_axis_tvalid;
      d1_v_q    <= l_valid;
      d2_v_q    <= d1_v_q;
      d3_v_q    <= d2_v_q;
      d4_v_q    <= d3_v_q;
      e1_v_q    <= r_valid;
      pv_q      <= {pv_q[POW_STAGES-1:0], e1_v_q};
      c1_v_q    <= pv_q[POW_STAGES];
      c2_v_q    <= c1_v_q;
      c3_v_q    <= c2_v_q;
      c4_v_q    <= c3_v_q;
      m_valid_q <= c4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ip_q[i] <= s_axis_tdata[COORD_BITS*i +: COORD_BITS];
        in_q[i] <= s_axis_tdata[3*COORD_BITS + 32*i +: 32];
        // normal dot light
        nl_q[i]    <= PW'(64'(nu[i]) * 64'(lu[i]));
        d1_n_q[i]  <= nu[i];
        d1_l_q[i]  <= lu[i];
        d1_v3_q[i] <= vu[i];
        d2_n_q[i]  <= d1_n_q[i];
        d2_l_q[i]  <= d1_l_q[i];
        d2_v3_q[i] <= d1_v3_q[i];
        // reflection vector
        np_q[i]    <= PW'(64'(d2_n_q[i]) * 64'(d2_ndl_q));
        d3_l_q[i]  <= d2_l_q[i];
        d3_v3_q[i] <= d2_v3_q[i];
        rr_q[i]    <= RW'((rnd_sh(64'(np_q[i]), FRAC_BITS) <<< 1) - 64'(d3_l_q[i]));
        d4_v3_q[i] <= d3_v3_q[i];
        // reflection dot view
        rv_q[i]    <= PW'(64'(ru[i]) * 64'(rs_v[i]));
        // colour
        t1_q[i]    <= T_W'($signed(64'(kdd_q[i])) * 64'(pn_q[POW_STAGES]));
        t2_q[i]    <= T_W'($signed(64'(kss_q[i])) * 64'(pw_q[POW_STAGES]));
        inner_q[i] <= IN_W'(rnd_sh(64'(t1_q[i]) + 64'(t2_q[i]), FRAC_BITS));
        x_q[i]     <= X_W'(rnd_sh(64'(inner_q[i]) * $signed(64'(lcol_q[16*i +: 16])), 16));
        lit_q[i]   <= LIT_W'(rnd_sh(64'(x_q[i]) * $signed(64'(coef_q[63:48])), 12));
      end
      islot_q  <= s_axis_tuser;
      d1_s_q   <= l_side;
      d2_s_q   <= d1_s_q;
      d2_ndl_q <= UW'(clamp_unit(rnd_sh(nl_sum, FRAC_BITS), FRAC_BITS));
      d3_s_q   <= d2_s_q;
      d3_ndl_q <= d2_ndl_q;
      d4_s_q   <= d3_s_q;
      d4_ndl_q <= d3_ndl_q;
      e1_ndl_q <= $signed(r_side[3*UW+2 +: UW]);
      e1_s_q   <= r_side[3*UW +: 2];
      pw_q[0]  <= UNIT_ONE;
      pr_q[0]  <= UW'(clamp_unit(rnd_sh(rv_sum, FRAC_BITS), FRAC_BITS));
      pn_q[0]  <= e1_ndl_q;
      ps_q[0]  <= e1_s_q;
      for (int k = 0; k < POW_STAGES; k++) begin
        pw_q[k+1] <= pw_d[k];
        pr_q[k+1] <= pr_q[k];
        pn_q[k+1] <= pn_q[k];
        ps_q[k+1] <= ps_q[k];
      end
      c1_s_q   <= ps_q[POW_STAGES];
      c2_s_q   <= c1_s_q;
      c3_s_q   <= c2_s_q;
      c4_s_q   <= c3_s_q;
      m_data_q <= {chan[2], chan[1], chan[0]};
      m_user_q <= c4_s_q;
    end
  end

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pv_q))
    else $error("power chain valid bits moved during a stall");

  a_norms_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l_valid |-> (n_valid && v_valid))
    else $error("light, normal and view normalizers out of step");

  a_power_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q[POW_STAGES] |-> (pw_q[POW_STAGES] <= UNIT_ONE && pw_q[POW_STAGES] >= -UNIT_ONE))
    else $error("specular power left the unit range");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for phong_vertex_shader_unit: random and directed vertices,
// several light setups, and a bit-exact lighting prediction kept in a scoreboard class.
// Depends on pvs_pkg and the design sources only.

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] slot;
} shade_t;

class shade_scoreboard;
  logic [47:0] light_pos, view_pos, light_col, ambient, diffuse, specular;
  logic [63:0] coeff;
  logic [6:0]  shininess;
  shade_t      expected_shades[$];
  int          errors;

  function new();
    light_pos = pvs_pkg::RST_LIGHT_POS;
    view_pos  = pvs_pkg::RST_VIEW_POS;
    light_col = pvs_pkg::RST_LIGHT_COL;
    ambient   = pvs_pkg::RST_AMBIENT;
    diffuse   = pvs_pkg::RST_DIFFUSE;
    specular  = pvs_pkg::RST_SPECULAR;
    coeff     = pvs_pkg::RST_COEFF;
    shininess = pvs_pkg::RST_SHININESS;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      pvs_pkg::REG_LIGHT_POS: light_pos = data[47:0];
      pvs_pkg::REG_VIEW_POS:  view_pos  = data[47:0];
      pvs_pkg::REG_LIGHT_COL: light_col = data[47:0];
      pvs_pkg::REG_AMBIENT:   ambient   = data[47:0];
      pvs_pkg::REG_DIFFUSE:   diffuse   = data[47:0];
      pvs_pkg::REG_SPECULAR:  specular  = data[47:0];
      pvs_pkg::REG_COEFF:     coeff     = data;
      default:                shininess = data[6:0];
    endcase
  endfunction

  function int pending();
    return expected_shades.size();
  endfunction

  // shift right, rounding half away from zero
  function longint shr_round(longint x, int sh);
    longint unsigned mag, r;
    mag = (x < 0) ? longint'(-x) : x;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function longint clip_unit(longint x);
    if (x > 65536) return 65536;
    if (x < -65536) return -65536;
    return x;
  endfunction

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 16) + (len >> 1)) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function longint dot_unit(longint a[3], longint b[3]);
    return clip_unit(shr_round(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 16));
  endfunction

  function longint field16(logic [63:0] r, int k);
    return longint'(r[16*k +: 16]);
  endfunction

  function void note_vertex(logic [143:0] data, logic [1:0] slot);
    longint lv[3], vv[3], nv[3], lu[3], vu[3], nu[3], rr[3], ru[3];
    longint p, ndl, rdv, pw, ka, kd, ks, att, a, d, s, lc, amb, inner, lit, c;
    logic [7:0] chan[3];
    shade_t sh;
    for (int i = 0; i < 3; i++) begin
      p = longint'($signed(data[16*i +: 16]));
      lv[i] = p - longint'($signed(light_pos[16*i +: 16]));
      vv[i] = p - longint'($signed(view_pos[16*i +: 16]));
      nv[i] = longint'($signed(data[48 + 32*i +: 32]));
    end
    unit_vec(lv, lu);
    unit_vec(nv, nu);
    unit_vec(vv, vu);
    ndl = dot_unit(nu, lu);
    for (int i = 0; i < 3; i++) rr[i] = 2 * shr_round(nu[i] * ndl, 16) - lu[i];
    unit_vec(rr, ru);
    rdv = dot_unit(ru, vu);
    pw = 65536;
    for (int k = 0; k < shininess; k++) pw = clip_unit(shr_round(pw * rdv, 16));
    ka = field16(coeff, 0);
    kd = field16(coeff, 1);
    ks = field16(coeff, 2);
    att = field16(coeff, 3);
    for (int i = 0; i < 3; i++) begin
      a = field16(ambient, i);
      d = field16(diffuse, i);
      s = field16(specular, i);
      lc = field16(light_col, i);
      amb = shr_round(a * d, 16) * ka;
      inner = shr_round(kd * d * ndl + ks * s * pw, 16);
      lit = shr_round(shr_round(inner * lc, 16) * att, 12);
      c = amb + lit;
      if (c < 0) c = 0;
      if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
      chan[i] = 8'((c * 255 + (64'sd1 <<< 29)) >>> 30);
    end
    sh.red = chan[0];
    sh.green = chan[1];
    sh.blue = chan[2];
    sh.slot = slot;
    expected_shades.insert(expected_shades.size(), sh);
  endfunction

  function void check_shade(logic [23:0] data, logic [1:0] user);
    shade_t want;
    if (expected_shades.size() == 0) begin
      $display("%0t: unexpected result %h/%h", $time, data, user);
      errors++;
      return;
    end
    want = expected_shades.pop_front();
    if (data[7:0] !== want.red) begin
      $display("%0t: red expected %0d actual %0d", $time, want.red, data[7:0]);
      errors++;
    end
    if (data[15:8] !== want.green) begin
      $display("%0t: green expected %0d actual %0d", $time, want.green, data[15:8]);
      errors++;
    end
    if (data[23:16] !== want.blue) begin
      $display("%0t: blue expected %0d actual %0d", $time, want.blue, data[23:16]);
      errors++;
    end
    if (user !== want.slot) begin
      $display("%0t: slot expected %0d actual %0d", $time, want.slot, user);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import pvs_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [63:0]  cfg_data_i = '0;

  shade_scoreboard sb = new();
  int  hold_cycles = 0;
  bit  no_gaps = 0;

  always #5 clk_i = ~clk_i;

  phong_vertex_shader_unit u_dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_vertex(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_shade(m_axis_tdata, m_axis_tuser);
  end

  // result side: random stalls, plus a long hold when requested
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic program_all(logic [47:0] lp, logic [47:0] vp, logic [47:0] lc,
                             logic [47:0] am, logic [47:0] df, logic [47:0] sp,
                             logic [63:0] cf, logic [6:0] shin);
    write_reg(REG_LIGHT_POS, {16'h0, lp});
    write_reg(REG_VIEW_POS, {16'h0, vp});
    write_reg(REG_LIGHT_COL, {16'h0, lc});
    write_reg(REG_AMBIENT, {16'h0, am});
    write_reg(REG_DIFFUSE, {16'h0, df});
    write_reg(REG_SPECULAR, {16'h0, sp});
    write_reg(REG_COEFF, cf);
    write_reg(REG_SHININESS, {57'h0, shin});
  endtask

  task automatic send_vertex(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [1:0] slot);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nz, ny, nx, pz, py, px};
    s_axis_tuser  <= slot;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] near_coord(logic [15:0] c);
    return c + 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic logic [31:0] rand_normal();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return 32'($signed($urandom_range(0, 4194304)) - 2097152);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [15:0] p[3];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        case (mode)
          0: p[i] = 16'($urandom);
          1: p[i] = near_coord(sb.light_pos[16*i +: 16]);
          2: p[i] = near_coord(sb.view_pos[16*i +: 16]);
          default: p[i] = 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
      end
      send_vertex(p[0], p[1], p[2], rand_normal(), rand_normal(), rand_normal(),
                  2'($urandom_range(0, 3)));
    end
  endtask

  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = rand64();
    return r[47:0];
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset setup: directed corner vertices, then random ones
    send_vertex('0, '0, '0, '0, '0, '0, 2'd0);
    send_vertex(16'hF8F8, 16'h0960, 16'hFE48, 32'h0001_0000, '0, '0, 2'd1);
    send_vertex(16'h0000, 16'h00F0, 16'h00F0, '0, 32'h0001_0000, '0, 2'd2);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 2'd3);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 2'd0);
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, 2'd1);
    send_vertex(16'h8000, 16'h7FFF, 16'h8000, '0, '0, 32'hFFFF_FFFF, 2'd2);
    send_vertex(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_0000, 32'h0001_0000, '0, 2'd3);
    send_vertex(16'h0000, 16'h0000, 16'h0000, 32'h0001_0000, 32'hFFFF_0000, '0, 2'd0);
    send_vertex(16'h0064, 16'h0064, 16'h0064, '0, 32'h0001_0000, '0, 2'd1);
    send_vertex(16'h0064, 16'h0064, 16'h0064, '0, 32'hFFFF_0000, '0, 2'd2);
    send_vertex(16'h0001, 16'hFFFF, 16'h0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1, 2'd3);
    send_vertex(16'hFFFF, 16'h0000, 16'h0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 2'd0);
    send_random(200);
    drain();

    // random setup, mildest exponent; long output hold fills the pipeline
    program_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), rand64(), 7'd1);
    hold_cycles = 700;
    send_random(250);
    drain();

    // everything saturated, largest exponent
    program_all('1, '1, '1, '1, '1, '1, '1, 7'd127);
    send_random(200);
    drain();

    // everything zero, exponent zero
    program_all('0, '0, '0, '0, '0, '0, '0, 7'd0);
    send_random(150);
    drain();

    // random colours, exponent at its usual top, no idling on either side
    no_gaps = 1;
    program_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
                rand64(), 7'd64);
    send_random(250);
    drain();
    no_gaps = 0;

    // opposite corners for light and viewer
    program_all(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, rand48(), rand48(), rand48(),
                rand48(), rand64(), 7'($urandom_range(1, 64)));
    send_random(250);
    drain();

    program_all(RST_LIGHT_POS, RST_VIEW_POS, RST_LIGHT_COL, RST_AMBIENT, RST_DIFFUSE,
                RST_SPECULAR, RST_COEFF, 7'd2);
    send_random(200);
    drain();

    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
